// File: hw/rtl/tcs_pkg.sv
`default_nettype none

package tcs_pkg;

  // Store geometry defaults
  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 32;
  localparam int DEF_MAX_FRAMES = 4;

  // Cell layout: colors in the upper byte, glyph in the lower byte
  localparam int CELL_W = 16;
  localparam logic [7:0] RESET_COLORS = 8'h07;  // gray on black
  localparam logic [7:0] RESET_GLYPH  = 8'h00;

  // Glyph codes with special handling
  localparam logic [7:0] GLYPH_BLANK = 8'd0;
  localparam logic [7:0] GLYPH_SPACE = 8'd32;
  localparam logic [7:0] GLYPH_LEFT  = 8'd221;
  localparam logic [7:0] GLYPH_RIGHT = 8'd222;

  // Configuration reset values
  localparam logic [5:0] RST_IMAGE_WIDTH   = 6'd32;
  localparam logic [5:0] RST_IMAGE_HEIGHT  = 6'd32;
  localparam logic [2:0] RST_FRAME_COUNT   = 3'd1;
  localparam logic [8:0] RST_BUFFER_WIDTH  = 9'd80;
  localparam logic [8:0] RST_BUFFER_HEIGHT = 9'd25;
  localparam logic [4:0] RST_TRANSPARENT   = 5'h1F;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_FRAME_COUNT   = 3'd2,
    REG_BUFFER_WIDTH  = 3'd3,
    REG_BUFFER_HEIGHT = 3'd4,
    REG_TRANSPARENT   = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_GLYPH = 3'd0,
    KIND_FORE  = 3'd1,
    KIND_BACK  = 3'd2,
    KIND_READ  = 3'd3,
    KIND_DRAW  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_FULL = 2'd1,
    ACT_FORE = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;    // write reset value at the sweep address
    logic capture;  // take the request, launch the store read
    logic commit;   // write back and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last entry
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcs_ram.sv
`default_nettype none

module tcs_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read of the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcs_ctrl.sv
`default_nettype none

module tcs_ctrl
  import tcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequence: clear sweep, then take a request, then commit it
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcs_datapath.sv
`default_nettype none

module tcs_datapath
  import tcs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT * MAX_FRAMES,
  parameter int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  // configuration
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [8:0]        cfg_data,
  // request fields
  input  wire logic [2:0]        kind,
  input  wire logic [1:0]        frame,
  input  wire logic signed [8:0] pos_x,
  input  wire logic signed [8:0] pos_y,
  input  wire logic [4:0]        offset_x,
  input  wire logic [4:0]        offset_y,
  input  wire logic [7:0]        value,
  input  wire logic              mirror,
  // store port
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_addr,
  output logic [CELL_W-1:0]      ram_wdata,
  input  wire logic [CELL_W-1:0] ram_rdata,
  // result
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             action,
  output logic [7:0]             dest_x,
  output logic [7:0]             dest_y,
  output logic [3:0]             fore_color,
  output logic [3:0]             back_color,
  output logic [7:0]             glyph
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

  // Configuration registers
  logic [5:0] image_width, image_height;
  logic [2:0] frame_count;
  logic [8:0] buffer_width, buffer_height;
  logic [4:0] transparent_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= RST_IMAGE_WIDTH;
      image_height      <= RST_IMAGE_HEIGHT;
      frame_count       <= RST_FRAME_COUNT;
      buffer_width      <= RST_BUFFER_WIDTH;
      buffer_height     <= RST_BUFFER_HEIGHT;
      transparent_color <= RST_TRANSPARENT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width       <= cfg_data[5:0];
        REG_IMAGE_HEIGHT:  image_height      <= cfg_data[5:0];
        REG_FRAME_COUNT:   frame_count       <= cfg_data[2:0];
        REG_BUFFER_WIDTH:  buffer_width      <= cfg_data;
        REG_BUFFER_HEIGHT: buffer_height     <= cfg_data;
        REG_TRANSPARENT:   transparent_color <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep counter
  logic [ADDR_W-1:0] clear_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear) begin
      clear_cnt <= clear_cnt + ADDR_W'(1);
    end
  end

  assign status.clear_last = (clear_cnt == ADDR_W'(DEPTH - 1));

  // Effective bounds
  logic [31:0] w_cap, h_cap, f_cap, bw_cap, bh_cap;

  always_comb begin
    w_cap  = (32'(image_width) < 32'(MAX_WIDTH)) ? 32'(image_width) : 32'(MAX_WIDTH);
    h_cap  = (32'(image_height) < 32'(MAX_HEIGHT)) ? 32'(image_height) : 32'(MAX_HEIGHT);
    f_cap  = (32'(frame_count) < 32'(MAX_FRAMES)) ? 32'(frame_count) : 32'(MAX_FRAMES);
    bw_cap = (32'(buffer_width) < 32'd256) ? 32'(buffer_width) : 32'd256;
    bh_cap = (32'(buffer_height) < 32'd256) ? 32'(buffer_height) : 32'd256;
  end

  // Decode the request: source cell, its address and the clip tests
  logic              is_draw;
  logic signed [9:0] col, row, dx, dy;
  logic              cell_ok, ox_ok, dest_ok, draw_ok;
  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] addr_in;

  always_comb begin
    is_draw = (kind == KIND_DRAW);
    if (is_draw) begin
      col = mirror ? (10'(w_cap) - 10'sd1 - 10'(offset_x)) : 10'(offset_x);
      row = 10'(offset_y);
    end else begin
      col = 10'(pos_x);
      row = 10'(pos_y);
    end
    cell_ok = !col[9] && !row[9]
              && (32'(col[8:0]) < w_cap)
              && (32'(row[8:0]) < h_cap)
              && (32'(frame) < f_cap);
    addr_full = 32'(frame) * 32'(CELLS) + 32'(row[8:0]) * 32'(MAX_WIDTH)
                + 32'(col[8:0]);
    addr_in = addr_full[ADDR_W-1:0];
    ox_ok   = (32'(offset_x) < w_cap);
    dx      = 10'(pos_x) + 10'(offset_x);
    dy      = 10'(pos_y) + 10'(offset_y);
    dest_ok = !dx[9] && !dy[9] && (32'(dx[8:0]) < bw_cap) && (32'(dy[8:0]) < bh_cap);
    draw_ok = ox_ok && cell_ok && dest_ok;
  end

  // Hold the decoded request until commit
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        kind_q;
  logic [7:0]        value_q;
  logic              mirror_q, cell_ok_q, draw_ok_q;
  logic [7:0]        dx_q, dy_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q    <= addr_in;
      kind_q    <= kind;
      value_q   <= value;
      mirror_q  <= mirror;
      cell_ok_q <= cell_ok;
      draw_ok_q <= is_draw && draw_ok;
      dx_q      <= dx[7:0];
      dy_q      <= dy[7:0];
    end
  end

  // Store port: sweep, read at capture, read or write the held cell otherwise
  logic [7:0] cur_colors, cur_glyph;
  logic       key_hit;

  assign cur_colors = ram_rdata[15:8];
  assign cur_glyph  = ram_rdata[7:0];
  assign key_hit    = !transparent_color[4] && (transparent_color[3:0] == cur_colors[7:4]);

  always_comb begin
    if (cmd.clear) begin
      ram_addr = clear_cnt;
    end else if (cmd.capture) begin
      ram_addr = addr_in;
    end else begin
      ram_addr = addr_q;
    end
  end

  // Build write-back and result from the cell read
  logic [1:0] act_next;
  logic [7:0] dx_next, dy_next, glyph_next;
  logic [3:0] fore_next, back_next;
  logic       wr_hit;
  logic [CELL_W-1:0] wdata_upd;

  always_comb begin
    act_next   = ACT_NONE;
    dx_next    = '0;
    dy_next    = '0;
    fore_next  = '0;
    back_next  = '0;
    glyph_next = '0;
    wr_hit     = 1'b0;
    wdata_upd  = ram_rdata;
    case (kind_q)
      KIND_GLYPH: begin
        wr_hit    = cell_ok_q;
        wdata_upd = {cur_colors, value_q};
      end
      KIND_FORE: begin
        wr_hit    = cell_ok_q;
        wdata_upd = {cur_colors[7:4], value_q[3:0], cur_glyph};
      end
      KIND_BACK: begin
        wr_hit    = cell_ok_q;
        wdata_upd = {value_q[3:0], cur_colors[3:0], cur_glyph};
      end
      KIND_READ: begin
        act_next = ACT_READ;
        if (cell_ok_q) begin
          fore_next  = cur_colors[3:0];
          back_next  = cur_colors[7:4];
          glyph_next = cur_glyph;
        end
      end
      KIND_DRAW: begin
        if (draw_ok_q) begin
          if (!key_hit) begin
            act_next  = ACT_FULL;
            back_next = cur_colors[7:4];
          end else if (cur_glyph != GLYPH_BLANK && cur_glyph != GLYPH_SPACE) begin
            act_next = ACT_FORE;
          end
        end
        if (act_next != ACT_NONE) begin
          dx_next   = dx_q;
          dy_next   = dy_q;
          fore_next = cur_colors[3:0];
          // Swap the half-block glyphs when flipped
          if (mirror_q && cur_glyph == GLYPH_LEFT) begin
            glyph_next = GLYPH_RIGHT;
          end else if (mirror_q && cur_glyph == GLYPH_RIGHT) begin
            glyph_next = GLYPH_LEFT;
          end else begin
            glyph_next = cur_glyph;
          end
        end
      end
      default: ;
    endcase
  end

  assign ram_we    = cmd.clear || (cmd.commit && wr_hit);
  assign ram_wdata = cmd.clear ? {RESET_COLORS, RESET_GLYPH} : wdata_upd;

  // Result register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action     <= act_next;
      dest_x     <= dx_next;
      dest_y     <= dy_next;
      fore_color <= fore_next;
      back_color <= back_next;
      glyph      <= glyph_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_cell_sprite_store_and_blit.sv
// A request is taken in the idle state, which launches the store read; the
// execute state writes the cell back through the single store port and loads
// the result register once it is free, and only then is a new request taken.
// Reset: synchronous; afterwards a clearing pass writes gray on black, glyph 0,
// into every cell, MAX_FRAMES*MAX_WIDTH*MAX_HEIGHT cells (4096 by default),
// while in_stall stays high. Configuration writes are taken during the pass.
`default_nettype none

module text_cell_sprite_store_and_blit
  import tcs_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [8:0]        cfg_data,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        kind,
  input  wire logic [1:0]        frame,
  input  wire logic signed [8:0] pos_x,
  input  wire logic signed [8:0] pos_y,
  input  wire logic [4:0]        offset_x,
  input  wire logic [4:0]        offset_y,
  input  wire logic [7:0]        value,
  input  wire logic              mirror,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             action,
  output logic [7:0]             dest_x,
  output logic [7:0]             dest_y,
  output logic [3:0]             fore_color,
  output logic [3:0]             back_color,
  output logic [7:0]             glyph
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_FRAMES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t              cmd;
  status_t           status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tcs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_FRAMES (MAX_FRAMES),
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .frame      (frame),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .value      (value),
    .mirror     (mirror),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .fore_color (fore_color),
    .back_color (back_color),
    .glyph      (glyph)
  );

  tcs_ram #(
    .WIDTH  (CELL_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tcs_pkg::*;

  localparam int CELL_COLS   = DEF_MAX_WIDTH;
  localparam int CELL_ROWS   = DEF_MAX_HEIGHT;
  localparam int STORE_CELLS = DEF_MAX_FRAMES * DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int BUF_LIMIT   = 256;
  localparam int RAND_PER_PHASE = 120;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 250;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        frame;
    logic signed [8:0] px;
    logic signed [8:0] py;
    logic [4:0]        ox;
    logic [4:0]        oy;
    logic [7:0]        val;
    logic              mir;
  } cell_req_t;

  localparam int REQ_W = $bits(cell_req_t);

  typedef struct packed {
    action_t    act;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] gl;
  } cell_res_t;

  typedef struct {
    cell_req_t req;
    logic      typed;
    cell_res_t res;
  } dir_row_t;

  typedef struct {
    int iw, ih, fc, bw, bh, key;
  } blit_setting_t;

  // image w, image h, frames, buffer w, buffer h, key
  blit_setting_t plan [7] = '{
    '{4, 3, 2, 8, 6, 5},
    '{32, 32, 4, 256, 256, -1},
    '{1, 1, 1, 1, 1, 0},
    '{8, 8, 4, 40, 20, 0},
    '{16, 5, 3, 200, 100, 15},
    '{32, 32, 1, 80, 25, -1},
    '{5, 7, 4, 12, 9, 7}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [2:0] kind;
  logic [1:0] frame;
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic [4:0] offset_x;
  logic [4:0] offset_y;
  logic [7:0] value;
  logic mirror;
  logic out_valid;
  logic out_stall;
  logic [1:0] action;
  logic [7:0] dest_x;
  logic [7:0] dest_y;
  logic [3:0] fore_color;
  logic [3:0] back_color;
  logic [7:0] glyph;

  // Shadow of the cell store and its settings
  logic [7:0] shadow_colors [STORE_CELLS];
  logic [7:0] shadow_glyphs [STORE_CELLS];
  int img_w, img_h, frames_used, buf_w, buf_h;
  logic signed [4:0] key_color;

  cell_res_t pending_results [$];
  cell_res_t head_result;
  int fail_count = 0;
  int accepted_reqs = 0;
  bit steady = 1'b0;
  bit held_long = 1'b0;

  always #5 clk = ~clk;

  text_cell_sprite_store_and_blit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .frame(frame), .pos_x(pos_x), .pos_y(pos_y),
    .offset_x(offset_x), .offset_y(offset_y), .value(value), .mirror(mirror),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .dest_x(dest_x), .dest_y(dest_y),
    .fore_color(fore_color), .back_color(back_color), .glyph(glyph)
  );

  function automatic int cap_to(input int v, input int limit);
    return (v < limit) ? v : limit;
  endfunction

  // Locate a sprite cell; false when it lies outside the image or frames in use
  function automatic bit cell_lookup(input logic [1:0] fr, input int x, input int y,
                                     output int addr);
    addr = 0;
    if (x < 0 || y < 0) return 1'b0;
    if (x >= cap_to(img_w, CELL_COLS) || y >= cap_to(img_h, CELL_ROWS)) return 1'b0;
    if (int'(fr) >= cap_to(frames_used, DEF_MAX_FRAMES)) return 1'b0;
    addr = int'(fr) * CELL_COLS * CELL_ROWS + y * CELL_COLS + x;
    return 1'b1;
  endfunction

  // Apply one request to the shadow store and return the result it yields
  function automatic cell_res_t blit_predict(input cell_req_t r);
    cell_res_t o;
    int addr, w, sx, dx, dy;
    logic [7:0] col, g;
    o = '0;
    case (r.kind)
      KIND_GLYPH: begin
        if (cell_lookup(r.frame, int'(r.px), int'(r.py), addr)) shadow_glyphs[addr] = r.val;
      end
      KIND_FORE: begin
        if (cell_lookup(r.frame, int'(r.px), int'(r.py), addr))
          shadow_colors[addr][3:0] = r.val[3:0];
      end
      KIND_BACK: begin
        if (cell_lookup(r.frame, int'(r.px), int'(r.py), addr))
          shadow_colors[addr][7:4] = r.val[3:0];
      end
      KIND_READ: begin
        o.act = ACT_READ;
        if (cell_lookup(r.frame, int'(r.px), int'(r.py), addr)) begin
          o.fg = shadow_colors[addr][3:0];
          o.bg = shadow_colors[addr][7:4];
          o.gl = shadow_glyphs[addr];
        end
      end
      KIND_DRAW: begin
        w = cap_to(img_w, CELL_COLS);
        sx = r.mir ? (w - 1 - int'(r.ox)) : int'(r.ox);
        dx = int'(r.px) + int'(r.ox);
        dy = int'(r.py) + int'(r.oy);
        if (int'(r.ox) < w && cell_lookup(r.frame, sx, int'(r.oy), addr) &&
            dx >= 0 && dy >= 0 && dx < cap_to(buf_w, BUF_LIMIT) &&
            dy < cap_to(buf_h, BUF_LIMIT)) begin
          col = shadow_colors[addr];
          g = shadow_glyphs[addr];
          // swap the half-block glyphs when flipped
          if (r.mir && g == GLYPH_LEFT) g = GLYPH_RIGHT;
          else if (r.mir && g == GLYPH_RIGHT) g = GLYPH_LEFT;
          if (int'(col[7:4]) != int'(key_color)) begin
            o.act = ACT_FULL;
            o.bg = col[7:4];
          end else if (shadow_glyphs[addr] != GLYPH_BLANK &&
                       shadow_glyphs[addr] != GLYPH_SPACE) begin
            o.act = ACT_FORE;
          end
          if (o.act != ACT_NONE) begin
            o.dx = dx[7:0];
            o.dy = dy[7:0];
            o.fg = col[3:0];
            o.gl = g;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic cell_req_t mk(input logic [2:0] k, input int f, input int px,
                                   input int py, input int ox, input int oy, input int v,
                                   input int m);
    cell_req_t r;
    r.kind = k; r.frame = 2'(f); r.px = 9'(px); r.py = 9'(py);
    r.ox = 5'(ox); r.oy = 5'(oy); r.val = 8'(v); r.mir = 1'(m);
    return r;
  endfunction

  function automatic cell_res_t res_of(input action_t a, input int fg, input int bg,
                                       input int gl);
    cell_res_t o;
    o = '0;
    o.act = a; o.fg = 4'(fg); o.bg = 4'(bg); o.gl = 8'(gl);
    return o;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(0, 4))
      0: return GLYPH_BLANK;
      1: return GLYPH_SPACE;
      2: return GLYPH_LEFT;
      3: return GLYPH_RIGHT;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_color();
    case ($urandom_range(0, 3))
      0: return (key_color >= 0) ? 4'(key_color) : 4'($urandom);
      1: return RESET_COLORS[7:4];
      2: return RESET_COLORS[3:0];
      default: return 4'($urandom);
    endcase
  endfunction

  // Random request aimed mostly at live cells and visible destinations
  function automatic cell_req_t rand_req();
    cell_req_t r;
    int w, h, sel, dx;
    w = cap_to(img_w, CELL_COLS);
    h = cap_to(img_h, CELL_ROWS);
    r = cell_req_t'(REQ_W'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 4) r.kind = KIND_DRAW + 3'($urandom_range(1, 3));
    else if (sel < 22) r.kind = KIND_GLYPH;
    else if (sel < 36) r.kind = KIND_FORE;
    else if (sel < 50) r.kind = KIND_BACK;
    else if (sel < 65) r.kind = KIND_READ;
    else r.kind = KIND_DRAW;
    if ($urandom_range(0, 4) != 0)
      r.frame = 2'($urandom_range(0, cap_to(frames_used, DEF_MAX_FRAMES) - 1));
    case (r.kind)
      KIND_GLYPH: if ($urandom_range(0, 9) < 7) r.val = pick_glyph();
      KIND_FORE, KIND_BACK: if ($urandom_range(0, 3) != 0) r.val = {4'($urandom), pick_color()};
      default: ;
    endcase
    sel = $urandom_range(0, 99);
    if (r.kind == KIND_DRAW) begin
      if (sel < 85) begin
        r.ox = 5'($urandom_range(0, w - 1));
        r.oy = 5'($urandom_range(0, h - 1));
        dx = $urandom_range(0, cap_to(buf_w, BUF_LIMIT) - 1);
        r.px = 9'(dx - int'(r.ox));
        r.py = 9'(int'($urandom_range(0, cap_to(buf_h, BUF_LIMIT) - 1)) - int'(r.oy));
      end
    end else if (sel < 80) begin
      r.px = 9'($urandom_range(0, w - 1));
      r.py = 9'($urandom_range(0, h - 1));
    end else if (sel < 90) begin
      r.px = 9'($urandom_range(0, CELL_COLS - 1));
      r.py = 9'($urandom_range(0, CELL_ROWS - 1));
    end
    return r;
  endfunction

  task automatic put_reg(input reg_index_t idx, input int data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 9'(data);
    @(posedge clk);
  endtask

  // Write every register and mirror it into the shadow settings
  task automatic apply_setting(input blit_setting_t s);
    put_reg(REG_IMAGE_WIDTH, s.iw);
    put_reg(REG_IMAGE_HEIGHT, s.ih);
    put_reg(REG_FRAME_COUNT, s.fc);
    put_reg(REG_BUFFER_WIDTH, s.bw);
    put_reg(REG_BUFFER_HEIGHT, s.bh);
    put_reg(REG_TRANSPARENT, s.key & 31);
    cfg_write <= 1'b0;
    img_w = s.iw; img_h = s.ih; frames_used = s.fc;
    buf_w = s.bw; buf_h = s.bh; key_color = 5'(s.key);
  endtask

  // Offer one request, hold it until taken, then queue its result
  task automatic send_req(input cell_req_t r, input logic typed, input cell_res_t typed_res);
    int gap;
    cell_res_t p;
    gap = steady ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind; frame <= r.frame; pos_x <= r.px; pos_y <= r.py;
    offset_x <= r.ox; offset_y <= r.oy; value <= r.val; mirror <= r.mir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = blit_predict(r);
    pending_results.push_back(typed ? typed_res : p);
    accepted_reqs++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  // Sender side: reset, directed table, then random phases
  initial begin
    dir_row_t rows [$];
    rst <= 1'b1;
    cfg_write <= 1'b0; cfg_index <= REG_IMAGE_WIDTH; cfg_data <= '0;
    in_valid <= 1'b0; kind <= KIND_GLYPH; frame <= '0; pos_x <= '0; pos_y <= '0;
    offset_x <= '0; offset_y <= '0; value <= '0; mirror <= 1'b0;
    for (int i = 0; i < STORE_CELLS; i++) begin
      shadow_colors[i] = RESET_COLORS;
      shadow_glyphs[i] = RESET_GLYPH;
    end

    // Directed table, run under the first setting (4x3 image, 2 frames, 8x6 buffer, key 5)
    rows.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     res_of(ACT_READ, int'(RESET_COLORS[3:0]), int'(RESET_COLORS[7:4]),
                            int'(RESET_GLYPH))});
    rows.push_back('{mk(KIND_READ, 0, -1, 0, 0, 0, 0, 0), 1'b1, res_of(ACT_READ, 0, 0, 0)});
    rows.push_back('{mk(KIND_READ, 3, 0, 0, 0, 0, 0, 0), 1'b1, res_of(ACT_READ, 0, 0, 0)});
    rows.push_back('{mk(KIND_READ, 0, 255, -256, 31, 31, 255, 1), 1'b1,
                     res_of(ACT_READ, 0, 0, 0)});
    rows.push_back('{mk(KIND_READ, 0, -256, 255, 0, 0, 0, 0), 1'b1, res_of(ACT_READ, 0, 0, 0)});
    rows.push_back('{mk(KIND_GLYPH, 0, 1, 0, 0, 0, int'(GLYPH_LEFT), 0), 1'b1,
                     res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_FORE, 0, 1, 0, 0, 0, 'hFA, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_BACK, 0, 1, 0, 0, 0, 5, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_READ, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_GLYPH, 0, 4, 0, 0, 0, 'h55, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_READ, 0, 4, 0, 0, 0, 0, 0), 1'b1, res_of(ACT_READ, 0, 0, 0)});
    rows.push_back('{mk(KIND_GLYPH, 1, 3, 2, 0, 0, 255, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_BACK, 1, 3, 2, 0, 0, 'hFF, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_FORE, 1, 3, 2, 0, 0, 0, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_READ, 1, 3, 2, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_DRAW, 0, 0, 0, 1, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_DRAW, 0, 0, 0, 2, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(KIND_GLYPH, 0, 2, 0, 0, 0, int'(GLYPH_SPACE), 0), 1'b1,
                     res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_BACK, 0, 2, 0, 0, 0, 5, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_DRAW, 0, 0, 0, 2, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_DRAW, 0, -1, 0, 0, 0, 0, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_DRAW, 0, 8, 0, 0, 0, 0, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_DRAW, 1, 4, 3, 3, 2, 0, 0), 1'b0, '0});
    rows.push_back('{mk(KIND_DRAW, 0, 0, 0, 31, 0, 0, 0), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_DRAW, 0, 0, 0, 0, 31, 0, 1), 1'b1, res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_DRAW + 3'd1, 3, 255, 255, 31, 31, 255, 1), 1'b1,
                     res_of(ACT_NONE, 0, 0, 0)});
    rows.push_back('{mk(KIND_DRAW + 3'd3, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     res_of(ACT_NONE, 0, 0, 0)});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < $size(plan); p++) begin
      if (p > 0) begin
        drain_results();
        repeat (4) @(posedge clk);
      end
      apply_setting(plan[p]);
      steady = (p % 3 == 2);
      if (p == 0) begin
        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);
      end else begin
        repeat (RAND_PER_PHASE) send_req(rand_req(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** text_cell_sprite_store_and_blit: PASSED **");
    end else begin
      $display("** text_cell_sprite_store_and_blit: FAILED **");
    end
    $finish;
  end

  // Receiver side: random stalls, one long hold to back the block up
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (!held_long && accepted_reqs >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = steady ? 0 : pick_idle();
        if (n == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Compare each taken result with the oldest pending one
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, action %0d", $time, action);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("action", 8'(head_result.act), 8'(action));
        check_field("dest_x", head_result.dx, dest_x);
        check_field("dest_y", head_result.dy, dest_y);
        check_field("fore_color", 8'(head_result.fg), 8'(fore_color));
        check_field("back_color", 8'(head_result.bg), 8'(back_color));
        check_field("glyph", head_result.gl, glyph);
      end
    end
  end

  // Hard stop
  initial begin
    #5000000;
    $display("** text_cell_sprite_store_and_blit: FAILED **");
    $finish;
  end

endmodule
